// ===== hdl/lgr_pkg.sv =====
// Shared field widths, command codes and the control bundle of the life grid column cells.
`timescale 1ns / 1ps

package lgr_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 6;
  localparam int GEN_W    = 32;
  localparam int LIVE_W   = 12;

  // Command codes carried in the action field of an input transaction.
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  // Per-cycle controls broadcast from the sequencer to every column cell.
  typedef struct packed {
    logic shift;  // a new grid row is on the read bus; move the window down
    logic count;  // the window center row is interior; count its live cells
  } cell_ctrl_t;

endpackage

// ===== hdl/life_grid_generation_step_core.sv =====
// Top level of the life grid generation step core: sequencer, grid RAM and column cell chain.
`timescale 1ns / 1ps

// The core keeps a GRID_WIDTH by GRID_HEIGHT grid of one-bit cells and takes one
// command per input transaction on the in_ channel: write a cell, read a cell,
// advance one B3/S23 generation, or clear the grid. Every command yields exactly one
// result transaction on the out_ channel carrying the cell value, the generation
// count and the live interior cell count of the most recent step.
// The grid lives in a RAM with one grid row per word. A step streams the rows through
// a chain of GRID_WIDTH column cells, one row per cycle, and writes each new interior
// row back once the row below it has entered the window. The live count rides along
// the cell chain and drains out of its end after the last row, in the drain state.
// A cell write or read inside the grid first reads the row from the RAM and then
// responds; outside the grid it responds at once. A step sweeps the rows and drains
// the count chain; a clear sweeps the rows with zeros. One command is in work at a
// time; in_tready is high whenever the sequencer is idle, even while a previous
// result still waits in the output register. After reset the core zeroes the grid
// RAM one row per cycle with in_tready low. If the receiver stalls, the result holds
// in the output register and the next command waits in its response state until
// that register frees.
module life_grid_generation_step_core
  import lgr_pkg::*;
#(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // From bit 0: action[1:0], col[7:2], row[13:8], cell_in[14], zero [15].
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // From bit 0: cell_out[0], generation[32:1], live_seen[44:33], zero [47:45].
  output logic [47:0] out_tdata
);

  localparam int ROW_W  = $clog2(GRID_HEIGHT);
  localparam int CIDX_W = $clog2(GRID_WIDTH);
  localparam int CNT_W  = $clog2(GRID_WIDTH + 1);
  localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CELL  = 6'b000100,
    ST_STEP  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  // Sequencer state.
  state_t              state_r, state_nxt;
  logic [ROW_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic                rd_done_r, rd_done_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [ROW_W-1:0]    rd_row_r, rd_row_nxt;
  logic                win_vld_r, win_vld_nxt;
  logic [ROW_W-1:0]    win_row_r, win_row_nxt;
  logic [CIDX_W-1:0]   drn_cnt_r, drn_cnt_nxt;
  logic                init_resp_r, init_resp_nxt;
  logic [GEN_W-1:0]    gen_r, gen_nxt;
  logic [LIVE_W-1:0]   last_live_r, last_live_nxt;
  logic [LIVE_W-1:0]   live_sum_r, live_sum_nxt;
  logic                out_vld_r, out_vld_nxt;

  // Command and result payload.
  action_t             act_r, act_nxt;
  logic [CIDX_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic                val_r, val_nxt;
  logic                res_cell_r, res_cell_nxt;
  logic                out_cell_r, out_cell_nxt;
  logic [GEN_W-1:0]    out_gen_r, out_gen_nxt;
  logic [LIVE_W-1:0]   out_live_r, out_live_nxt;

  // Input transaction fields.
  action_t             in_action;
  logic [POS_W-1:0]    in_col;
  logic [POS_W-1:0]    in_row;
  logic                in_cell;
  logic                in_fire;
  logic                in_inside;

  // RAM ports.
  logic                  ram_we;
  logic [ROW_W-1:0]      ram_waddr;
  logic [GRID_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ROW_W-1:0]      ram_raddr;
  logic [GRID_WIDTH-1:0] ram_rdata;

  // Cell chain.
  cell_ctrl_t            cell_ctrl;
  logic [1:0]            vs_pad [GRID_WIDTH+2];
  logic [CNT_W-1:0]      acc_w  [GRID_WIDTH+1];
  logic [GRID_WIDTH-1:0] next_row;
  logic [GRID_WIDTH-1:0] cell_row;

  logic                  step_rd;
  logic                  step_wr;
  logic                  row_last;
  logic                  drn_last;
  logic [LIVE_W:0]       live_wide;
  logic [LIVE_W-1:0]     live_sum_sat;

  assign in_action = action_t'(in_tdata[ACTION_W-1:0]);
  assign in_col    = in_tdata[ACTION_W +: POS_W];
  assign in_row    = in_tdata[ACTION_W+POS_W +: POS_W];
  assign in_cell   = in_tdata[ACTION_W+2*POS_W];
  assign in_inside = (32'(in_col) < 32'(GRID_WIDTH)) && (32'(in_row) < 32'(GRID_HEIGHT));

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign row_last = (row_cnt_r == ROW_W'(GRID_HEIGHT - 1));
  assign drn_last = (drn_cnt_r == CIDX_W'(GRID_WIDTH - 1));

  // Reads run two rows ahead of the window's bottom row; a row is written back once its lower
  // neighbor has arrived, which is when the window's bottom row is at least two.
  assign step_rd = (state_r == ST_STEP) && !rd_done_r;
  assign step_wr = win_vld_r && (win_row_r >= ROW_W'(2));

  assign cell_ctrl.shift = rd_vld_r;
  assign cell_ctrl.count = step_wr;

  // The live count leaves the far end of the chain and is summed with saturation.
  assign live_wide    = {1'b0, live_sum_r} + (LIVE_W + 1)'(acc_w[GRID_WIDTH]);
  assign live_sum_sat = live_wide[LIVE_W] ? LIVE_MAX : live_wide[LIVE_W-1:0];

  // Row image for a single cell write: the stored row with one bit replaced.
  always_comb begin
    cell_row        = ram_rdata;
    cell_row[col_r] = val_r;
  end

  lgr_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Columns outside the grid contribute nothing; the end cells are border
  // columns and keep their value, so the padding only keeps the chain regular.
  assign vs_pad[0]            = 2'b00;
  assign vs_pad[GRID_WIDTH+1] = 2'b00;
  assign acc_w[0]             = '0;

  for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
    localparam bit BORDER = (c == 0) || (c == GRID_WIDTH - 1);

    lgr_cell #(
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .is_border  (BORDER),
      .bit_in     (ram_rdata[c]),
      .vsum_left  (vs_pad[c]),
      .vsum_right (vs_pad[c+2]),
      .vsum       (vs_pad[c+1]),
      .next_bit   (next_row[c]),
      .acc_in     (acc_w[c]),
      .acc_out    (acc_w[c+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    row_cnt_nxt   = row_cnt_r;
    rd_done_nxt   = rd_done_r;
    rd_vld_nxt    = step_rd;
    rd_row_nxt    = row_cnt_r;
    win_vld_nxt   = rd_vld_r;
    win_row_nxt   = rd_row_r;
    drn_cnt_nxt   = drn_cnt_r;
    init_resp_nxt = init_resp_r;
    gen_nxt       = gen_r;
    last_live_nxt = last_live_r;
    live_sum_nxt  = live_sum_r;
    out_vld_nxt   = out_vld_r && !out_tready;

    act_nxt       = act_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    val_nxt       = val_r;
    res_cell_nxt  = res_cell_r;
    out_cell_nxt  = out_cell_r;
    out_gen_nxt   = out_gen_r;
    out_live_nxt  = out_live_r;

    ram_we    = 1'b0;
    ram_waddr = row_cnt_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = row_cnt_r;

    case (state_r)
      ST_INIT: begin
        // Zero sweep over the grid rows, after reset and for a clear command.
        ram_we = 1'b1;
        if (row_last) begin
          row_cnt_nxt = '0;
          state_nxt   = init_resp_r ? ST_RESP : ST_IDLE;
        end else begin
          row_cnt_nxt = row_cnt_r + ROW_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          act_nxt      = in_action;
          col_nxt      = CIDX_W'(in_col);
          row_nxt      = ROW_W'(in_row);
          val_nxt      = in_cell;
          res_cell_nxt = 1'b0;
          case (in_action)
            ACT_WRITE, ACT_READ: begin
              if (in_inside) begin
                ram_re    = 1'b1;
                ram_raddr = ROW_W'(in_row);
                state_nxt = ST_CELL;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            ACT_STEP: begin
              row_cnt_nxt  = '0;
              rd_done_nxt  = 1'b0;
              live_sum_nxt = '0;
              state_nxt    = ST_STEP;
            end
            ACT_CLEAR: begin
              gen_nxt       = '0;
              last_live_nxt = '0;
              init_resp_nxt = 1'b1;
              row_cnt_nxt   = '0;
              state_nxt     = ST_INIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_CELL: begin
        if (act_r == ACT_WRITE) begin
          ram_we       = 1'b1;
          ram_waddr    = row_r;
          ram_wdata    = cell_row;
          res_cell_nxt = val_r;
        end else begin
          res_cell_nxt = ram_rdata[col_r];
        end
        state_nxt = ST_RESP;
      end
      ST_STEP: begin
        if (step_rd) begin
          ram_re = 1'b1;
          if (row_last) begin
            rd_done_nxt = 1'b1;
          end else begin
            row_cnt_nxt = row_cnt_r + ROW_W'(1);
          end
        end
        if (step_wr) begin
          ram_we    = 1'b1;
          ram_waddr = win_row_r - ROW_W'(1);
          ram_wdata = next_row;
        end
        live_sum_nxt = live_sum_sat;
        if (win_vld_r && (win_row_r == ROW_W'(GRID_HEIGHT - 1))) begin
          drn_cnt_nxt = '0;
          state_nxt   = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        live_sum_nxt = live_sum_sat;
        drn_cnt_nxt  = drn_cnt_r + CIDX_W'(1);
        if (drn_last) begin
          gen_nxt       = gen_r + GEN_W'(1);
          last_live_nxt = live_sum_sat;
          state_nxt     = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt   = 1'b1;
          out_cell_nxt  = res_cell_r;
          out_gen_nxt   = gen_r;
          out_live_nxt  = last_live_r;
          init_resp_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      row_cnt_r   <= '0;
      rd_done_r   <= 1'b1;
      rd_vld_r    <= 1'b0;
      rd_row_r    <= '0;
      win_vld_r   <= 1'b0;
      win_row_r   <= '0;
      drn_cnt_r   <= '0;
      init_resp_r <= 1'b0;
      gen_r       <= '0;
      last_live_r <= '0;
      live_sum_r  <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_cnt_r   <= row_cnt_nxt;
      rd_done_r   <= rd_done_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_row_r    <= rd_row_nxt;
      win_vld_r   <= win_vld_nxt;
      win_row_r   <= win_row_nxt;
      drn_cnt_r   <= drn_cnt_nxt;
      init_resp_r <= init_resp_nxt;
      gen_r       <= gen_nxt;
      last_live_r <= last_live_nxt;
      live_sum_r  <= live_sum_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    val_r      <= val_nxt;
    res_cell_r <= res_cell_nxt;
    out_cell_r <= out_cell_nxt;
    out_gen_r  <= out_gen_nxt;
    out_live_r <= out_live_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_live_r, out_gen_r, out_cell_r};

  // The RAM is never written while the core waits for a command.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("grid RAM written while idle");

  // A step only ever rewrites interior rows.
  a_step_interior: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STEP) && ram_we) |->
      ((ram_waddr != '0) && (ram_waddr != ROW_W'(GRID_HEIGHT - 1))))
    else $error("step wrote a border row");

  // The write-back row trails the read row, so they never coincide.
  a_step_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STEP) && ram_we && ram_re) |-> (ram_raddr != ram_waddr))
    else $error("step read and write hit the same row");

  // The window only carries rows during a step.
  a_window_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    win_vld_r |-> (state_r == ST_STEP))
    else $error("window valid outside a step");

  // Finishing the drain advances the generation by exactly one.
  a_gen_advance: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DRAIN) && drn_last) |=> (gen_r == $past(gen_r) + GEN_W'(1)))
    else $error("generation did not advance by one");

endmodule

// ===== hdl/lgr_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module lgr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/lgr_cell.sv =====
// One column cell: a three-row window, the B3/S23 rule and a systolic live count stage.
`timescale 1ns / 1ps

module lgr_cell
  import lgr_pkg::*;
#(
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic             is_border,
  input  logic             bit_in,
  input  logic [1:0]       vsum_left,
  input  logic [1:0]       vsum_right,
  output logic [1:0]       vsum,
  output logic             next_bit,
  input  logic [CNT_W-1:0] acc_in,
  output logic [CNT_W-1:0] acc_out
);

  logic             top_r, mid_r, bot_r;
  logic             top_nxt, mid_nxt, bot_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [3:0]       nbr;
  logic             rule_bit;
  logic             live_bit;

  assign vsum = {1'b0, top_r} + {1'b0, mid_r} + {1'b0, bot_r};

  // Neighbor count is the 3x3 column sum less the center cell itself.
  assign nbr = {2'b00, vsum_left} + {2'b00, vsum} + {2'b00, vsum_right} - {3'b000, mid_r};
  assign rule_bit = mid_r ? ((nbr == 4'd2) || (nbr == 4'd3)) : (nbr == 4'd3);
  assign next_bit = is_border ? mid_r : rule_bit;

  assign live_bit = ctrl.count && mid_r && !is_border;

  always_comb begin
    top_nxt = top_r;
    mid_nxt = mid_r;
    bot_nxt = bot_r;
    if (ctrl.shift) begin
      top_nxt = mid_r;
      mid_nxt = bot_r;
      bot_nxt = bit_in;
    end
    // The partial count never exceeds the number of cells upstream, so it fits.
    acc_nxt = acc_in + CNT_W'(live_bit);
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    mid_r <= mid_nxt;
    bot_r <= bot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_out = acc_r;

endmodule

// ===== tb/tb_life_grid_generation_step_core.sv =====
// Self-checking testbench for the life grid generation step core.
`timescale 1ns / 1ps

// The bench drives grid commands on the in_ stream and checks every out_ transaction
// against a shadow copy of the grid kept in this module. The shadow grid is updated at
// the moment a command transaction is accepted, and the result that it predicts is
// queued. Each result transaction that leaves the core is compared field by field
// with the oldest queued result.
// The stimulus opens with a short table of directed commands and then runs random
// bursts. Most bursts write a cluster of cells into a small window, which may touch
// the border, and then step the grid a few times with reads in the same window. That
// way the generations have live neighborhoods to work on. The other bursts are
// weighted random noise over all four commands and the full position range.
// Three idling phases follow each other: a mostly stalling receiver, then a mostly
// idle sender, then full throughput. One long receiver hold-off makes the core back
// up and stall its input, and one sender pause lets every outstanding result drain.
module tb_life_grid_generation_step_core
  import lgr_pkg::*;
();

  localparam int GRID_W      = 64;
  localparam int GRID_H      = 64;
  localparam int RANDOM_CMDS = 1425;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = GRID_W + GRID_H + 16;

  // Field order follows the bus layout: the last member lands in the lowest bits.
  typedef struct packed {
    logic             cell_in;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    action_t          action;
  } grid_cmd_t;

  typedef struct packed {
    logic [LIVE_W-1:0] live_seen;
    logic [GEN_W-1:0]  generation;
    logic              cell_out;
  } grid_result_t;

  typedef struct {
    grid_cmd_t    cmd;
    bit           typed;
    grid_result_t want;
  } directed_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  // Shadow state of the core: one word per grid row, bit index is the column.
  logic [GRID_W-1:0] shadow_grid [GRID_H];
  logic [GEN_W-1:0]  shadow_gen;
  logic [LIVE_W-1:0] shadow_live;

  grid_result_t  life_results_due [$];
  directed_row_t directed_rows [$];

  int  err_count;
  int  results_checked;
  int  cycle_count;
  int  random_sent;
  int  n_write, n_read, n_step, n_clear;
  int  peak_live;
  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  hold_request;

  life_grid_generation_step_core #(
    .GRID_WIDTH  (GRID_W),
    .GRID_HEIGHT (GRID_H)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Hard stop in case the core hangs or loses a result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, life_results_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    if (err_count < 40) begin
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    end
    err_count++;
  endtask

  // One synchronous B3/S23 generation over the interior, computed from a snapshot so
  // that every cell sees the old neighborhood. Border cells stay as they are but are
  // still counted as neighbors.
  function automatic void advance_generation();
    logic [GRID_W-1:0] snap [GRID_H];
    int n;
    int live;
    snap = shadow_grid;
    live = 0;
    for (int r = 1; r < GRID_H - 1; r++) begin
      for (int c = 1; c < GRID_W - 1; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += int'(snap[r + dr][c + dc]);
            end
          end
        end
        if (snap[r][c]) begin
          live++;
          shadow_grid[r][c] = (n == 2 || n == 3);
        end else begin
          shadow_grid[r][c] = (n == 3);
        end
      end
    end
    shadow_live = (live > 4095) ? 12'hFFF : LIVE_W'(live);
    shadow_gen  = shadow_gen + 1'b1;
    if (live > peak_live) begin
      peak_live = live;
    end
  endfunction

  // Applies one accepted command to the shadow state and returns the result it causes.
  function automatic grid_result_t next_life_result(grid_cmd_t c);
    grid_result_t res;
    logic         cell_bit;
    cell_bit = 1'b0;
    case (c.action)
      ACT_WRITE: begin
        shadow_grid[c.row][c.col] = c.cell_in;
        cell_bit = c.cell_in;
        n_write++;
      end
      ACT_READ: begin
        cell_bit = shadow_grid[c.row][c.col];
        n_read++;
      end
      ACT_STEP: begin
        advance_generation();
        n_step++;
      end
      default: begin
        shadow_grid = '{default: '0};
        shadow_gen  = '0;
        shadow_live = '0;
        n_clear++;
      end
    endcase
    res.cell_out   = cell_bit;
    res.generation = shadow_gen;
    res.live_seen  = shadow_live;
    return res;
  endfunction

  // Offers one command, waits for its transaction, and queues what it should return.
  // Rows of the directed table may carry a hand-written result instead.
  task automatic send_command(grid_cmd_t c, bit typed = 1'b0, grid_result_t want = '0);
    grid_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, c};
    do @(posedge clk); while (!in_tready);
    predicted = next_life_result(c);
    life_results_due = {life_results_due, (typed ? want : predicted)};
  endtask

  task automatic add_row(action_t act, int col, int row, bit cin, bit typed = 1'b0,
                         int w_cell = 0, longint w_gen = 0, int w_live = 0);
    directed_row_t d;
    d.cmd.action        = act;
    d.cmd.col           = POS_W'(col);
    d.cmd.row           = POS_W'(row);
    d.cmd.cell_in       = cin;
    d.typed             = typed;
    d.want.cell_out     = 1'(w_cell);
    d.want.generation   = GEN_W'(w_gen);
    d.want.live_seen    = LIVE_W'(w_live);
    directed_rows = {directed_rows, d};
  endtask

  task automatic send_random(action_t act, int col, int row, bit cin);
    grid_cmd_t c;
    c.action  = act;
    c.col     = POS_W'(col);
    c.row     = POS_W'(row);
    c.cell_in = cin;
    send_command(c);
    random_sent++;
  endtask

  // A cluster of writes in one window, then a few generations with reads of the window.
  task automatic pattern_burst();
    int w, r0, c0;
    w  = $urandom_range(3, 12);
    r0 = $urandom_range(0, GRID_H - w);
    c0 = $urandom_range(0, GRID_W - w);
    repeat ($urandom_range(3, 3 * w)) begin
      send_random(ACT_WRITE, c0 + $urandom_range(0, w - 1), r0 + $urandom_range(0, w - 1),
                  $urandom_range(99) < 75);
    end
    repeat ($urandom_range(1, 4)) begin
      send_random(ACT_STEP, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1),
                  1'($urandom_range(1)));
      repeat ($urandom_range(0, 3)) begin
        send_random(ACT_READ, c0 + $urandom_range(0, w - 1), r0 + $urandom_range(0, w - 1),
                    1'($urandom_range(1)));
      end
    end
  endtask

  // Unstructured commands over the whole field ranges; clears are kept rare so that
  // the grid keeps some population most of the time.
  task automatic noise_burst();
    int pick;
    action_t act;
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(99);
      if (pick < 45) act = ACT_WRITE;
      else if (pick < 80) act = ACT_READ;
      else if (pick < 96) act = ACT_STEP;
      else act = ACT_CLEAR;
      send_random(act, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1),
                  1'($urandom_range(1)));
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off counted here on request.
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Result checker: every result transaction must match the oldest queued result.
  always @(posedge clk) begin
    grid_result_t got;
    grid_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[44:0];
      if (life_results_due.size() == 0) begin
        report_mismatch("result with nothing outstanding", got, 0);
      end else begin
        want = life_results_due.pop_front();
        results_checked++;
        if (got.cell_out !== want.cell_out) begin
          report_mismatch("cell_out", got.cell_out, want.cell_out);
        end
        if (got.generation !== want.generation) begin
          report_mismatch("generation", got.generation, want.generation);
        end
        if (got.live_seen !== want.live_seen) begin
          report_mismatch("live_seen", got.live_seen, want.live_seen);
        end
      end
    end
  end

  initial begin
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    rst_n        = 1'b0;
    err_count    = 0;
    cycle_count  = 0;
    hold_request = 1'b0;
    tx_idle_pct  = 12;
    rx_idle_pct  = 68;
    shadow_grid  = '{default: '0};
    shadow_gen   = '0;
    shadow_live  = '0;

    // Directed table. Results that follow plainly from reset, clear or a single write
    // are written out; the other rows are left to the shadow grid.
    add_row(ACT_READ,  5,  5,  1'b1, 1'b1, 0, 0, 0);   // untouched cell after reset
    add_row(ACT_WRITE, 0,  0,  1'b1, 1'b1, 1, 0, 0);   // all four corners
    add_row(ACT_WRITE, 63, 63, 1'b1, 1'b1, 1, 0, 0);
    add_row(ACT_WRITE, 63, 0,  1'b1, 1'b1, 1, 0, 0);
    add_row(ACT_WRITE, 0,  63, 1'b1, 1'b1, 1, 0, 0);
    add_row(ACT_READ,  63, 63, 1'b0, 1'b1, 1, 0, 0);
    add_row(ACT_WRITE, 0,  0,  1'b0, 1'b1, 0, 0, 0);   // writing a dead cell
    add_row(ACT_WRITE, 10, 9,  1'b1, 1'b1, 1, 0, 0);   // vertical blinker
    add_row(ACT_WRITE, 10, 10, 1'b1, 1'b1, 1, 0, 0);
    add_row(ACT_WRITE, 10, 11, 1'b1, 1'b1, 1, 0, 0);
    add_row(ACT_WRITE, 20, 0,  1'b1, 1'b1, 1, 0, 0);   // three live border cells
    add_row(ACT_WRITE, 21, 0,  1'b1, 1'b1, 1, 0, 0);
    add_row(ACT_WRITE, 22, 0,  1'b1, 1'b1, 1, 0, 0);
    add_row(ACT_STEP,  0,  0,  1'b0);
    add_row(ACT_READ,  9,  10, 1'b0);                  // blinker turned horizontal
    add_row(ACT_READ,  21, 1,  1'b0);                  // birth fed by the border row
    add_row(ACT_READ,  21, 0,  1'b0);                  // border cell left alone
    add_row(ACT_STEP,  0,  0,  1'b0);
    add_row(ACT_CLEAR, 17, 33, 1'b1, 1'b1, 0, 0, 0);
    add_row(ACT_READ,  10, 10, 1'b0, 1'b1, 0, 0, 0);
    add_row(ACT_STEP,  0,  0,  1'b0, 1'b1, 0, 1, 0);   // step on an empty grid
    add_row(ACT_WRITE, 62, 62, 1'b1);                  // three cells of a block against the far corner
    add_row(ACT_WRITE, 61, 62, 1'b1);
    add_row(ACT_WRITE, 62, 61, 1'b1);
    add_row(ACT_STEP,  0,  0,  1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end

    random_sent = 0;
    while (random_sent < RANDOM_CMDS) begin
      if (tx_idle_pct == 12 && random_sent >= RANDOM_CMDS / 3) begin
        // Let everything drain before the sender turns slow.
        in_tvalid <= 1'b0;
        do @(posedge clk); while (life_results_due.size() != 0);
        tx_idle_pct = 68;
        rx_idle_pct = 12;
      end else if (tx_idle_pct == 68 && random_sent >= 2 * RANDOM_CMDS / 3) begin
        // Full rate from here, starting with a long receiver hold-off.
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
      end
      if ($urandom_range(99) < 70) begin
        pattern_burst();
      end else begin
        noise_burst();
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (life_results_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Commands: %0d writes, %0d reads, %0d generation steps, %0d clears.",
             n_write, n_read, n_step, n_clear);
    $display("Results checked: %0d, peak live interior count %0d, mismatches %0d.",
             results_checked, peak_live, err_count);
    if (err_count == 0 && life_results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
